// ===== rtl/wsdf_pkg.sv =====
// shared types and constants for the websocket frame deframer
// no dependencies; used by rtl/websocket_frame_deframer.sv

package wsdf_pkg;

   // parser phase codes
   localparam logic [2:0] PH_HDR0  = 3'd0;
   localparam logic [2:0] PH_HDR1  = 3'd1;
   localparam logic [2:0] PH_LEN16 = 3'd2;
   localparam logic [2:0] PH_LEN64 = 3'd3;
   localparam logic [2:0] PH_MASK  = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_UNMASKED = 2'd1;
   localparam logic [1:0] ST_TOO_LONG = 2'd2;
   localparam logic [1:0] ST_CLOSE    = 2'd3;

   // opcodes with special handling
   localparam logic [3:0] OP_DATA_MAX = 4'h2;
   localparam logic [3:0] OP_PING     = 4'h9;
   localparam logic [3:0] OP_PONG     = 4'ha;

   // second header byte length markers
   localparam logic [6:0] LEN7_16BIT = 7'd126;
   localparam logic [6:0] LEN7_64BIT = 7'd127;

   // extended length byte counts, minus one
   localparam logic [2:0] LEN16_LEFT = 3'd1;
   localparam logic [2:0] LEN64_LEFT = 3'd7;

   localparam logic [63:0] MAX_LEN_RESET = 64'd2147483647;

   // one result item
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic       message_end;
      logic       send_pong;
      logic [1:0] status;
   } result_type;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// websocket client-to-server frame deframer, one received byte per item
// depends on rtl/wsdf_pkg.sv
//
// usage:
//   req_* carries the received byte stream, one byte per item. rsp_* carries
//   results: unmasked payload bytes of data and continuation frames, byteless
//   end marks, pong requests after a ping and error or close status.
//   csr_* writes the 64-bit limit on the 8-byte payload length form.
// latency: a result appears on rsp_* the cycle after its byte is taken; header,
//   length, mask and control payload bytes give one only at frame end or error.
// throughput: one byte per clock unless a held result stalls req_tready. the
//   parse of each byte is a single pass through the header/length/mask/data
//   logic into the state registers and the result register; the length compare
//   and the 64-bit length decrement set the longest path.
// stall: a result waits in the result register while rsp_tready is low;
//   req_tready then drops, and rises again in the cycle the result is taken.
// reset: synchronous. the parser waits for a first header byte, the limit
//   returns to 2147483647. after an unmasked frame, an over-long frame or a
//   close/unknown opcode the block keeps taking bytes and ignores them until
//   the next reset.

module websocket_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] payload_byte
   output logic        rsp_tlast,   // message_end
   output logic [3:0]  rsp_tuser,   // [0] byte_valid, [1] send_pong, [3:2] status
   // limit register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data     // max_payload_length
);

   logic [63:0] max_len_ff;
   logic [2:0]  phase_ff,     phase_in;
   logic        fin_ff,       fin_in;
   logic [3:0]  opcode_ff,    opcode_in;
   logic [2:0]  len_left_ff,  len_left_in;
   logic [63:0] remain_ff,    remain_in;
   logic [31:0] key_ff,       key_in;
   logic [1:0]  key_idx_ff,   key_idx_in;
   logic        halted_ff,    halted_in;
   logic        rsp_valid_ff;
   wsdf_pkg::result_type rsp_ff;

   logic                 req_take;
   logic                 res_fire;
   wsdf_pkg::result_type res;
   logic                 is_data;
   logic [63:0]          len_shift;
   logic [63:0]          remain_dec;
   logic [1:0]           key_idx_inc;
   logic [7:0]           key_byte;
   logic [7:0]           clear_byte;
   logic                 frame_done;
   logic                 done_has_byte;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   assign is_data     = opcode_ff <= wsdf_pkg::OP_DATA_MAX;
   assign len_shift   = {remain_ff[55:0], req_tdata};
   assign remain_dec  = remain_ff - 64'd1;
   assign key_idx_inc = key_idx_ff + 2'd1;

   // rotating mask key byte, first key byte in the top bits
   always_comb begin
      case (key_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end
   assign clear_byte = req_tdata ^ key_byte;

   // parse one byte
   always_comb begin
      phase_in      = phase_ff;
      fin_in        = fin_ff;
      opcode_in     = opcode_ff;
      len_left_in   = len_left_ff;
      remain_in     = remain_ff;
      key_in        = key_ff;
      key_idx_in    = key_idx_ff;
      halted_in     = halted_ff;
      res_fire      = 1'b0;
      res           = '0;
      frame_done    = 1'b0;
      done_has_byte = 1'b0;
      if (!halted_ff) begin
         case (phase_ff)
            wsdf_pkg::PH_HDR0: begin
               fin_in    = req_tdata[7];
               opcode_in = req_tdata[3:0];
               phase_in  = wsdf_pkg::PH_HDR1;
            end
            wsdf_pkg::PH_HDR1: begin
               if (!req_tdata[7]) begin
                  halted_in  = 1'b1;
                  res_fire   = 1'b1;
                  res.status = wsdf_pkg::ST_UNMASKED;
               end else begin
                  key_in     = '0;
                  key_idx_in = '0;
                  if (req_tdata[6:0] == wsdf_pkg::LEN7_16BIT) begin
                     remain_in   = '0;
                     len_left_in = wsdf_pkg::LEN16_LEFT;
                     phase_in    = wsdf_pkg::PH_LEN16;
                  end else if (req_tdata[6:0] == wsdf_pkg::LEN7_64BIT) begin
                     remain_in   = '0;
                     len_left_in = wsdf_pkg::LEN64_LEFT;
                     phase_in    = wsdf_pkg::PH_LEN64;
                  end else begin
                     remain_in = {57'd0, req_tdata[6:0]};
                     phase_in  = wsdf_pkg::PH_MASK;
                  end
               end
            end
            wsdf_pkg::PH_LEN16, wsdf_pkg::PH_LEN64: begin
               remain_in = len_shift;
               if (len_left_ff != 3'd0) begin
                  len_left_in = len_left_ff - 3'd1;
               end else if (phase_ff == wsdf_pkg::PH_LEN64 && len_shift > max_len_ff) begin
                  halted_in  = 1'b1;
                  res_fire   = 1'b1;
                  res.status = wsdf_pkg::ST_TOO_LONG;
               end else begin
                  phase_in = wsdf_pkg::PH_MASK;
               end
            end
            wsdf_pkg::PH_MASK: begin
               key_in     = {key_ff[23:0], req_tdata};
               key_idx_in = key_idx_inc;
               if (key_idx_inc == 2'd0) begin
                  if (remain_ff == 64'd0) begin
                     frame_done = 1'b1;
                  end else begin
                     phase_in = wsdf_pkg::PH_DATA;
                  end
               end
            end
            wsdf_pkg::PH_DATA: begin
               key_idx_in = key_idx_inc;
               remain_in  = remain_dec;
               if (remain_dec == 64'd0) begin
                  frame_done    = 1'b1;
                  done_has_byte = 1'b1;
               end else if (is_data) begin
                  res_fire         = 1'b1;
                  res.payload_byte = clear_byte;
                  res.byte_valid   = 1'b1;
               end
            end
            default: begin
               phase_in = wsdf_pkg::PH_HDR0;
            end
         endcase

         // end of frame handling
         if (frame_done) begin
            phase_in   = wsdf_pkg::PH_HDR0;
            key_idx_in = '0;
            if (is_data) begin
               if (done_has_byte) begin
                  res_fire         = 1'b1;
                  res.payload_byte = clear_byte;
                  res.byte_valid   = 1'b1;
                  res.message_end  = fin_ff;
               end else if (fin_ff) begin
                  res_fire        = 1'b1;
                  res.message_end = 1'b1;
               end
            end else if (opcode_ff == wsdf_pkg::OP_PING) begin
               res_fire      = 1'b1;
               res.send_pong = 1'b1;
            end else if (opcode_ff != wsdf_pkg::OP_PONG) begin
               halted_in  = 1'b1;
               res_fire   = 1'b1;
               res.status = wsdf_pkg::ST_CLOSE;
            end
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= wsdf_pkg::PH_HDR0;
         fin_ff      <= 1'b0;
         opcode_ff   <= '0;
         len_left_ff <= '0;
         remain_ff   <= '0;
         key_ff      <= '0;
         key_idx_ff  <= '0;
         halted_ff   <= 1'b0;
      end else if (req_take) begin
         phase_ff    <= phase_in;
         fin_ff      <= fin_in;
         opcode_ff   <= opcode_in;
         len_left_ff <= len_left_in;
         remain_ff   <= remain_in;
         key_ff      <= key_in;
         key_idx_ff  <= key_idx_in;
         halted_ff   <= halted_in;
      end
   end

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= wsdf_pkg::MAX_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take && res_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && res_fire) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.payload_byte;
   assign rsp_tlast  = rsp_ff.message_end;
   assign rsp_tuser  = {rsp_ff.status, rsp_ff.send_pong, rsp_ff.byte_valid};

endmodule
